[rtl/core/jdc_pkg.sv]
// Shared constants and helpers for the Julian Date to calendar converter.
// Holds the pipeline depth, the constant-divider reciprocals and the month table.
// No dependencies.
package jdc_pkg;

	// Default day-fraction width and the fixed input widths
	localparam int FRACTION_BITS_DEF = 32;
	localparam int WHOLE_W           = 23;
	localparam int FRAC_PORT_W       = 32;

	// Register stages from input to output, output register included
	localparam int NUM_STAGES = 9;

	// First day number (noon-shifted) that takes the Gregorian correction
	localparam int unsigned GREG_FIRST_J = 2299161;
	// floor(J/36524.25 - 51.12264) = floor((4*(J - GREG_EPOCH_J) - 1) / 146097)
	localparam int unsigned GREG_EPOCH_J = 1867216;

	// Century divider: 146097, dividend below 2^25
	localparam int unsigned DIVA_N = 146097;
	localparam int          DIVA_S = 25;
	localparam int unsigned DIVA_M = (1 << DIVA_S) / DIVA_N;

	// Year divider: floor((4*B - 489) / 1461), dividend below 2^26
	localparam int unsigned B_OFFSET = 1524;
	localparam int unsigned C_BIAS   = 489;
	localparam int unsigned DIVC_N   = 1461;
	localparam int          DIVC_S   = 26;
	localparam int unsigned DIVC_M   = (1 << DIVC_S) / DIVC_N;

	// Month divider: floor(100*x / 3061), x below 2^9
	localparam int unsigned DIVE_N = 3061;
	localparam int unsigned DIVE_K = 100;
	localparam int          DIVE_S = 12;
	localparam int unsigned DIVE_M = (DIVE_K << DIVE_S) / DIVE_N;

	localparam int unsigned YEAR_BASE = 4716;

	// Time of day
	localparam int unsigned SEC_PER_DAY = 86400;
	localparam int unsigned SIXTY       = 60;
	localparam int          DIV60_S     = 17;
	localparam int unsigned DIV60_M     = (1 << DIV60_S) / SIXTY;
	localparam int          DIVH_S      = 11;
	localparam int unsigned DIVH_M      = (1 << DIVH_S) / SIXTY;
	localparam int unsigned HOURS_DAY   = 24;

	// floor(30.61 * e): days ahead of month index e
	function automatic logic [8:0] month_days(input logic [3:0] e);
		logic [8:0] r;
		case (e)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd30;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd91;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd183;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd244;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd336;
			4'd12:   r = 9'd367;
			4'd13:   r = 9'd397;
			4'd14:   r = 9'd428;
			default: r = 9'd459;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/julian_day_to_calendar_core.sv]
// Julian Date to calendar date and UTC time, top level with handshake control.
// Instantiates jdc_date_path and jdc_time_path; depends on jdc_pkg.
//
//   channel | direction | handshake           | payload
//   jd      | in        | jd_valid/jd_ready   | jd_whole_days, jd_day_fraction
//   cal     | out       | cal_valid/cal_ready | year, month, day_of_month,
//           |           |                     | hour, minute, second
//
// One item per cycle while no stall holds the output; the depth is set by the date path
// (three reciprocal divides, each a multiply stage plus a correction stage).
// All stages move together on one enable; a stall holds every stage in place.
// jd_ready is low only while a result waits at the output and cal_ready is low.
// Reset clears the stage valid bits only; data registers are not reset.
module julian_day_to_calendar_core import jdc_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   jd_valid,
	output logic                   jd_ready,
	input  logic [WHOLE_W-1:0]     jd_whole_days,
	input  logic [FRAC_PORT_W-1:0] jd_day_fraction,
	output logic                   cal_valid,
	input  logic                   cal_ready,
	output logic signed [15:0]     year,
	output logic [3:0]             month,
	output logic [4:0]             day_of_month,
	output logic [4:0]             hour,
	output logic [5:0]             minute,
	output logic [5:0]             second
);

	logic                     en;
	logic [NUM_STAGES-1:0]    vld_q;
	logic [FRACTION_BITS-1:0] frac_w;

	// Fraction at the configured width; bits above it are ignored
	assign frac_w = FRACTION_BITS'(jd_day_fraction);

	// Shared stage enable
	assign en        = !vld_q[NUM_STAGES-1] || cal_ready;
	assign jd_ready  = en;
	assign cal_valid = vld_q[NUM_STAGES-1];

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NUM_STAGES-2:0], jd_valid};
		end
	end

	jdc_date_path u_date (
		.clk          (clk),
		.en           (en),
		.whole_days   (jd_whole_days),
		.upper_half   (frac_w[FRACTION_BITS-1]),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month)
	);

	jdc_time_path #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_time (
		.clk    (clk),
		.en     (en),
		.frac   (frac_w),
		.hour   (hour),
		.minute (minute),
		.second (second)
	);

	// Delivered month, hour, minute and second are within their calendar ranges and day of month is nonzero
	a_field_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid |-> (month >= 4'd1 && month <= 4'd12 &&
			day_of_month >= 5'd1 && hour <= 5'd23 &&
			minute <= 6'd59 && second <= 6'd59))
		else $error("result field out of range");

	// A stall freezes the stage valid bits
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("stage valid bits moved during stall");

	// A cycle with no item offered puts a bubble in the first stage
	a_bubble_in: assert property (@(posedge clk) disable iff (!arst_n)
		(jd_ready && !jd_valid) |=> !vld_q[0])
		else $error("first stage valid without an accepted item");

endmodule

[rtl/core/jdc_date_path.sv]
// Date half of the converter: day number to year, month and day of month.
// Nine register stages advanced by a shared enable. Depends on jdc_pkg.
module jdc_date_path import jdc_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [WHOLE_W-1:0] whole_days,
	input  logic               upper_half,
	output logic signed [15:0] year,
	output logic [3:0]         month,
	output logic [4:0]         day_of_month
);

	// Stage 1: civil day number, calendar select, century dividend
	logic [23:0] j_c;
	logic        greg_c;
	logic [24:0] xa_c;
	logic [23:0] j_s1;
	logic        greg_s1;
	logic [24:0] xa_s1;

	assign j_c    = 24'(whole_days) + 24'(upper_half);
	assign greg_c = j_c >= 24'(GREG_FIRST_J);
	assign xa_c   = greg_c ? 25'({j_c - 24'(GREG_EPOCH_J), 2'b00} - 26'd1) : '0;

	always_ff @(posedge clk) begin
		if (en) begin
			j_s1    <= j_c;
			greg_s1 <= greg_c;
			xa_s1   <= xa_c;
		end
	end

	// Stage 2: century quotient estimate
	logic [32:0] pa_c;
	logic [23:0] j_s2;
	logic        greg_s2;
	logic [24:0] xa_s2;
	logic [7:0]  qa0_s2;

	assign pa_c = 33'(xa_s1) * 33'(DIVA_M);

	always_ff @(posedge clk) begin
		if (en) begin
			j_s2    <= j_s1;
			greg_s2 <= greg_s1;
			xa_s2   <= xa_s1;
			qa0_s2  <= pa_c[DIVA_S +: 8];
		end
	end

	// Stage 3: estimate is low by at most one
	logic [25:0] ra_c;
	logic [23:0] j_s3;
	logic        greg_s3;
	logic [7:0]  a1_s3;

	assign ra_c = 26'(xa_s2) - 26'(qa0_s2) * 26'(DIVA_N);

	always_ff @(posedge clk) begin
		if (en) begin
			j_s3    <= j_s2;
			greg_s3 <= greg_s2;
			a1_s3   <= (ra_c >= 26'(DIVA_N)) ? qa0_s2 + 8'd1 : qa0_s2;
		end
	end

	// Stage 4: Gregorian correction, B and the year dividend
	logic [23:0] a_c;
	logic [23:0] b_c;
	logic [25:0] xc_c;
	logic [23:0] b_s4;
	logic [25:0] xc_s4;

	assign a_c  = greg_s3 ? j_s3 + 24'd1 + 24'(a1_s3) - 24'(a1_s3[7:2]) : j_s3;
	assign b_c  = a_c + 24'(B_OFFSET);
	assign xc_c = {b_c, 2'b00} - 26'(C_BIAS);

	always_ff @(posedge clk) begin
		if (en) begin
			b_s4  <= b_c;
			xc_s4 <= xc_c;
		end
	end

	// Stage 5: year quotient estimate
	logic [41:0] pc_c;
	logic [23:0] b_s5;
	logic [25:0] xc_s5;
	logic [14:0] qc0_s5;

	assign pc_c = 42'(xc_s4) * 42'(DIVC_M);

	always_ff @(posedge clk) begin
		if (en) begin
			b_s5   <= b_s4;
			xc_s5  <= xc_s4;
			qc0_s5 <= pc_c[DIVC_S +: 15];
		end
	end

	// Stage 6: correct C
	logic [25:0] rc_c;
	logic [23:0] b_s6;
	logic [14:0] c_s6;

	assign rc_c = xc_s5 - 26'(qc0_s5) * 26'(DIVC_N);

	always_ff @(posedge clk) begin
		if (en) begin
			b_s6 <= b_s5;
			c_s6 <= (rc_c >= 26'(DIVC_N)) ? qc0_s5 + 15'd1 : qc0_s5;
		end
	end

	// Stage 7: D = floor(365.25 C), days left in the shifted year
	logic [25:0] d4_c;
	logic [23:0] bd_c;
	logic [14:0] c_s7;
	logic [8:0]  bd_s7;

	assign d4_c = 26'(c_s6) * 26'(DIVC_N);
	assign bd_c = b_s6 - d4_c[25:2];

	always_ff @(posedge clk) begin
		if (en) begin
			c_s7  <= c_s6;
			bd_s7 <= bd_c[8:0];
		end
	end

	// Stage 8: month index estimate
	logic [15:0] pe_c;
	logic [14:0] c_s8;
	logic [8:0]  bd_s8;
	logic [3:0]  qe0_s8;

	assign pe_c = 16'(bd_s7) * 16'(DIVE_M);

	always_ff @(posedge clk) begin
		if (en) begin
			c_s8   <= c_s7;
			bd_s8  <= bd_s7;
			qe0_s8 <= pe_c[DIVE_S +: 4];
		end
	end

	// Stage 9: correct E, then day, month and year
	logic [15:0] re_c;
	logic [3:0]  e_c;
	logic [8:0]  day_c;
	logic [3:0]  mon_c;
	logic [15:0] yr_c;
	logic signed [15:0] year_s9;
	logic [3:0]  month_s9;
	logic [4:0]  day_s9;

	assign re_c  = 16'(bd_s8) * 16'(DIVE_K) - 16'(qe0_s8) * 16'(DIVE_N);
	assign e_c   = (re_c >= 16'(DIVE_N)) ? qe0_s8 + 4'd1 : qe0_s8;
	assign day_c = bd_s8 - month_days(e_c);
	assign mon_c = (e_c >= 4'd14) ? e_c - 4'd13 : e_c - 4'd1;
	assign yr_c  = 16'(c_s8) - 16'(YEAR_BASE) + 16'(mon_c < 4'd3);

	always_ff @(posedge clk) begin
		if (en) begin
			year_s9  <= signed'(yr_c);
			month_s9 <= mon_c;
			day_s9   <= day_c[4:0];
		end
	end

	assign year         = year_s9;
	assign month        = month_s9;
	assign day_of_month = day_s9;

endmodule

[rtl/core/jdc_time_path.sv]
// Time half of the converter: day fraction to hour, minute and rounded second.
// Nine register stages advanced by a shared enable. Depends on jdc_pkg.
module jdc_time_path import jdc_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [FRACTION_BITS-1:0] frac,
	output logic [4:0]               hour,
	output logic [5:0]               minute,
	output logic [5:0]               second
);

	localparam int PW = FRACTION_BITS + 17;
	localparam logic [PW-1:0] HALF = PW'(1) << (FRACTION_BITS - 1);

	// Stage 1: shift by half a day (toggle the top fraction bit)
	logic [FRACTION_BITS-1:0] g_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			g_s1 <= {~frac[FRACTION_BITS-1], frac[FRACTION_BITS-2:0]};
		end
	end

	// Stage 2: scale to seconds
	logic [PW-1:0] prod_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= PW'(g_s1) * PW'(SEC_PER_DAY);
		end
	end

	// Stage 3: round to whole seconds of day
	logic [PW-1:0] rsum_c;
	logic [16:0]   total_s3;

	assign rsum_c = prod_s2 + HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			total_s3 <= rsum_c[FRACTION_BITS +: 17];
		end
	end

	// Stage 4: minute count estimate
	logic [28:0] p60_c;
	logic [16:0] total_s4;
	logic [10:0] qm0_s4;

	assign p60_c = 29'(total_s3) * 29'(DIV60_M);

	always_ff @(posedge clk) begin
		if (en) begin
			total_s4 <= total_s3;
			qm0_s4   <= p60_c[DIV60_S +: 11];
		end
	end

	// Stage 5: correct minutes of day, seconds remain
	logic [16:0] rs_c;
	logic        rs_over;
	logic [10:0] qm_s5;
	logic [5:0]  sec_s5;

	assign rs_c    = total_s4 - 17'(qm0_s4) * 17'(SIXTY);
	assign rs_over = rs_c >= 17'(SIXTY);

	always_ff @(posedge clk) begin
		if (en) begin
			qm_s5  <= rs_over ? qm0_s4 + 11'd1 : qm0_s4;
			sec_s5 <= rs_over ? 6'(rs_c - 17'(SIXTY)) : rs_c[5:0];
		end
	end

	// Stage 6: hour estimate
	logic [16:0] ph_c;
	logic [10:0] qm_s6;
	logic [4:0]  qh0_s6;
	logic [5:0]  sec_s6;

	assign ph_c = 17'(qm_s5) * 17'(DIVH_M);

	always_ff @(posedge clk) begin
		if (en) begin
			qm_s6  <= qm_s5;
			qh0_s6 <= ph_c[DIVH_S +: 5];
			sec_s6 <= sec_s5;
		end
	end

	// Stage 7: correct hour, minutes remain, hour 24 wraps
	logic [10:0] rm_c;
	logic        rm_over;
	logic [4:0]  h_c;
	logic [4:0]  hour_s7;
	logic [5:0]  min_s7;
	logic [5:0]  sec_s7;

	assign rm_c    = qm_s6 - 11'(qh0_s6) * 11'(SIXTY);
	assign rm_over = rm_c >= 11'(SIXTY);
	assign h_c     = rm_over ? qh0_s6 + 5'd1 : qh0_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			hour_s7 <= (h_c >= 5'(HOURS_DAY)) ? h_c - 5'(HOURS_DAY) : h_c;
			min_s7  <= rm_over ? 6'(rm_c - 11'(SIXTY)) : rm_c[5:0];
			sec_s7  <= sec_s6;
		end
	end

	// Stages 8 and 9: align with the date path
	logic [4:0] hour_s8, hour_s9;
	logic [5:0] min_s8, min_s9;
	logic [5:0] sec_s8, sec_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			hour_s8 <= hour_s7;
			min_s8  <= min_s7;
			sec_s8  <= sec_s7;
			hour_s9 <= hour_s8;
			min_s9  <= min_s8;
			sec_s9  <= sec_s8;
		end
	end

	assign hour   = hour_s9;
	assign minute = min_s9;
	assign second = sec_s9;

endmodule
